FILE: rtl/svm_pkg.sv
package svm_pkg;

  // Widths and defaults.
  localparam int MV_W            = 16;
  localparam int PCT_W           = 7;
  localparam int CODE_W          = 4;
  localparam int ADC_BITS_MAX    = 12;
  localparam int ADC_BITS_DEF    = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CHG_W           = 4;

  // Millivolt scaling: raw * 21500 / 600 = raw * 215 / 6, done as one
  // multiplication by ceil(215 * 2^15 / 6) and a shift. The result is exact
  // for every raw value below 2^ADC_BITS_MAX.
  localparam int SCALE_SHIFT  = 15;
  localparam int SCALE_MUL    = 1174187;
  localparam int SCALE_PROD_W = ADC_BITS_MAX + 21;
  localparam int SCALE_Q_W    = SCALE_PROD_W - SCALE_SHIFT;

  // Division by 100 of a filter product (below 100 * 2^16) as a
  // multiplication by ceil(2^30 / 100) and a shift.
  localparam int PROD_W       = MV_W + PCT_W;
  localparam int DIV100_SHIFT = 30;
  localparam int DIV100_MUL   = 10737419;
  localparam int DIV100_M_W   = 24;
  localparam int DIV100_P_W   = PROD_W + DIV100_M_W;

  localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(100);
  localparam logic [MV_W-1:0]  FILTER_RESET = MV_W'(22300);
  localparam logic [MV_W-1:0]  MV_MAX       = '1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_OFF  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BATTERY_LOW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_ON     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_POWER_OFF    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RAIL_MIN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RAIL_MAX     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ESTOP_GAP    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_PCT   = 3'd7;

  // Battery classes share their values with the message codes.
  localparam logic [1:0] BATT_OFF  = 2'd0;
  localparam logic [1:0] BATT_LOW  = 2'd1;
  localparam logic [1:0] BATT_GOOD = 2'd2;

  // Message codes.
  localparam logic [CODE_W-1:0] CODE_SUMMARY   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_ESTOP_ON  = 4'd3;
  localparam logic [CODE_W-1:0] CODE_ESTOP_OFF = 4'd4;
  localparam logic [CODE_W-1:0] CODE_POWER_OK  = 4'd5;
  localparam logic [CODE_W-1:0] CODE_NO_POWER  = 4'd6;
  localparam logic [CODE_W-1:0] CODE_RAIL_OK   = 4'd7;
  localparam logic [CODE_W-1:0] CODE_RAIL_BAD  = 4'd8;

  // Change mask bit positions, in message order.
  localparam int CHG_BATT  = 0;
  localparam int CHG_ESTOP = 1;
  localparam int CHG_POWER = 2;
  localparam int CHG_RAIL  = 3;

  typedef logic [ADC_BITS_MAX-1:0] raw_t;
  typedef logic [MV_W-1:0]         mv_t;

  // One classified acquisition, handed from the front to the back.
  typedef struct packed {
    logic [CHG_W-1:0] chg;
    logic [1:0]       batt_class;
    logic             estop;
    logic             pwr_avail;
    logic             rail_ok;
    logic             relay;
    mv_t              filtered;
    mv_t              power_mv;
    mv_t              rail_mv;
  } rec_t;

  // One result word.
  typedef struct packed {
    logic              is_summary;
    logic [CODE_W-1:0] state_code;
    mv_t               filtered_mv;
    mv_t               power_mv;
    mv_t               rail_mv;
    logic              resistor_on;
    logic              battery_ok;
    logic              rail_ok;
    logic              estop_pressed;
    logic              last;
  } word_t;

  function automatic mv_t scale_mv(input raw_t raw);
    logic [SCALE_PROD_W-1:0] prod;
    logic [SCALE_Q_W-1:0]    q;
    prod = SCALE_PROD_W'(raw) * SCALE_PROD_W'(SCALE_MUL);
    q    = prod[SCALE_PROD_W-1:SCALE_SHIFT];
    return (q > SCALE_Q_W'(MV_MAX)) ? MV_MAX : q[MV_W-1:0];
  endfunction

  function automatic mv_t div100(input logic [PROD_W-1:0] x);
    logic [DIV100_P_W-1:0] prod;
    prod = DIV100_P_W'(x) * DIV100_P_W'(DIV100_MUL);
    return prod[DIV100_SHIFT +: MV_W];
  endfunction

endpackage

FILE: rtl/supply_voltage_monitor_unit.sv
// Path: an accepted word passes the input holding register, scaling, two
// filter multiply stages, filter sum, classification, queue, output register.
// Throughput: the filter loop takes one acquisition at a time and stalls in
// classification while the queue is full; the output side delivers one word
// per cycle while the receiver pops, 1 to 5 words per acquisition.
// Reset is synchronous: configuration, filter and classes return to defaults.
module supply_voltage_monitor_unit #(
  parameter int ADC_BITS    = svm_pkg::ADC_BITS_DEF,
  parameter int QUEUE_DEPTH = svm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [svm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [svm_pkg::MV_W-1:0]          cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [ADC_BITS-1:0]               perm_raw,
  input  logic [ADC_BITS-1:0]               power_raw,
  input  logic [ADC_BITS-1:0]               rail_raw,
  output logic                              empty,
  input  logic                              pop,
  output logic                              is_summary,
  output logic [svm_pkg::CODE_W-1:0]        state_code,
  output logic [svm_pkg::MV_W-1:0]          filtered_mv,
  output logic [svm_pkg::MV_W-1:0]          power_mv,
  output logic [svm_pkg::MV_W-1:0]          rail_mv,
  output logic                              resistor_on,
  output logic                              battery_ok,
  output logic                              rail_ok,
  output logic                              estop_pressed,
  output logic                              last
);
  import svm_pkg::*;

  logic  q_wr;
  logic  q_full;
  logic  q_rd;
  logic  q_empty;
  rec_t  q_in;
  rec_t  q_out;
  word_t word;

  svm_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .perm_raw  (perm_raw),
    .power_raw (power_raw),
    .rail_raw  (rail_raw),
    .q_push    (q_wr),
    .q_rec     (q_in),
    .q_full    (q_full)
  );

  svm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_in),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_out),
    .q_empty (q_empty)
  );

  svm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_out),
    .q_pop   (q_rd),
    .empty   (empty),
    .pop     (pop),
    .word    (word)
  );

  assign is_summary    = word.is_summary;
  assign state_code    = word.state_code;
  assign filtered_mv   = word.filtered_mv;
  assign power_mv      = word.power_mv;
  assign rail_mv       = word.rail_mv;
  assign resistor_on   = word.resistor_on;
  assign battery_ok    = word.battery_ok;
  assign rail_ok       = word.rail_ok;
  assign estop_pressed = word.estop_pressed;
  assign last          = word.last;

endmodule

FILE: rtl/svm_queue.sv
module svm_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  svm_pkg::rec_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output svm_pkg::rec_t rd_data,
  output logic          q_empty
);
  import svm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/svm_front.sv
module svm_front #(
  parameter int ADC_BITS = svm_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [svm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [svm_pkg::MV_W-1:0]       cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [ADC_BITS-1:0]            perm_raw,
  input  logic [ADC_BITS-1:0]            power_raw,
  input  logic [ADC_BITS-1:0]            rail_raw,
  output logic                           q_push,
  output svm_pkg::rec_t                  q_rec,
  input  logic                           q_full
);
  import svm_pkg::*;

  localparam logic [1:0] PWR_UNKNOWN = 2'd0;
  localparam logic [1:0] PWR_AVAIL   = 2'd1;
  localparam logic [1:0] PWR_NONE    = 2'd2;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_DIV  = 5'b00100,
    F_SUM  = 5'b01000,
    F_CLS  = 5'b10000
  } fstate_t;

  fstate_t state;
  fstate_t state_next;

  // Configuration.
  mv_t              battery_off_mv;
  mv_t              battery_low_mv;
  mv_t              power_on_mv;
  mv_t              power_off_mv;
  mv_t              rail_min_mv;
  mv_t              rail_max_mv;
  mv_t              estop_gap_mv;
  logic [PCT_W-1:0] filter_percent;

  // Input holding word.
  logic                hold_vld;
  logic [ADC_BITS-1:0] hold_perm;
  logic [ADC_BITS-1:0] hold_power;
  logic [ADC_BITS-1:0] hold_rail;

  // Working registers.
  mv_t               sc_perm;
  mv_t               sc_pw;
  mv_t               sc_rl;
  logic [PROD_W-1:0] prod_old;
  logic [PROD_W-1:0] prod_new;
  mv_t               q_old;
  mv_t               q_new;

  // Monitor state.
  mv_t        filtered;
  logic [1:0] batt_class;
  logic       estop_class;
  logic [1:0] pwr_class;
  logic       rail_class;
  logic       relay;

  logic             take;
  logic [PCT_W-1:0] pct;
  logic [MV_W:0]    filt_sum;
  mv_t              gap_thr;
  logic [1:0]       batt_next;
  logic             estop_next;
  logic [1:0]       pwr_next;
  logic             relay_next;
  logic             rail_next;

  assign q_push = (state == F_CLS) && !q_full;
  assign take   = hold_vld && ((state == F_IDLE) || q_push);
  assign full   = hold_vld && !take;
  assign pct    = (filter_percent > PCT_FULL) ? PCT_FULL : filter_percent;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (take) state_next = F_MUL;
      F_MUL:  state_next = F_DIV;
      F_DIV:  state_next = F_SUM;
      F_SUM:  state_next = F_CLS;
      F_CLS: begin
        if (!q_full) begin
          state_next = take ? F_MUL : F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Classification of the freshly filtered value and this word's readings.
  always_comb begin
    priority if (filtered < battery_off_mv) begin
      batt_next = BATT_OFF;
    end else if (filtered < battery_low_mv) begin
      batt_next = BATT_LOW;
    end else begin
      batt_next = BATT_GOOD;
    end

    // When the gap exceeds the filtered value the threshold wraps, which
    // the first term catches.
    gap_thr    = filtered - estop_gap_mv;
    estop_next = (filtered < estop_gap_mv) || (sc_pw < gap_thr);

    pwr_next   = pwr_class;
    relay_next = relay;
    priority if (sc_pw > power_on_mv) begin
      pwr_next   = PWR_AVAIL;
      relay_next = 1'b0;
    end else if (sc_pw < power_off_mv) begin
      pwr_next   = PWR_NONE;
      relay_next = 1'b1;
    end else begin
      pwr_next   = pwr_class;
      relay_next = relay;
    end

    rail_next = (sc_rl > rail_min_mv) && (sc_rl < rail_max_mv);

    q_rec.chg[CHG_BATT]  = (batt_next != batt_class);
    q_rec.chg[CHG_ESTOP] = (estop_next != estop_class);
    q_rec.chg[CHG_POWER] = (pwr_next != pwr_class);
    q_rec.chg[CHG_RAIL]  = (rail_next != rail_class);
    q_rec.batt_class     = batt_next;
    q_rec.estop          = estop_next;
    q_rec.pwr_avail      = (pwr_next == PWR_AVAIL);
    q_rec.rail_ok        = rail_next;
    q_rec.relay          = relay_next;
    q_rec.filtered       = filtered;
    q_rec.power_mv       = sc_pw;
    q_rec.rail_mv        = sc_rl;
  end

  assign filt_sum = {1'b0, q_old} + {1'b0, q_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      hold_vld       <= 1'b0;
      battery_off_mv <= MV_W'(18000);
      battery_low_mv <= MV_W'(21300);
      power_on_mv    <= MV_W'(18000);
      power_off_mv   <= MV_W'(16000);
      rail_min_mv    <= MV_W'(10000);
      rail_max_mv    <= MV_W'(14000);
      estop_gap_mv   <= MV_W'(1500);
      filter_percent <= PCT_W'(10);
      filtered       <= FILTER_RESET;
      batt_class     <= BATT_OFF;
      estop_class    <= 1'b1;
      pwr_class      <= PWR_UNKNOWN;
      rail_class     <= 1'b0;
      relay          <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BATTERY_OFF: battery_off_mv <= cfg_data;
          REG_BATTERY_LOW: battery_low_mv <= cfg_data;
          REG_POWER_ON:    power_on_mv    <= cfg_data;
          REG_POWER_OFF:   power_off_mv   <= cfg_data;
          REG_RAIL_MIN:    rail_min_mv    <= cfg_data;
          REG_RAIL_MAX:    rail_max_mv    <= cfg_data;
          REG_ESTOP_GAP:   estop_gap_mv   <= cfg_data;
          REG_FILTER_PCT:  filter_percent <= cfg_data[PCT_W-1:0];
        endcase
      end
      if (push && !full) begin
        hold_vld <= 1'b1;
      end else if (take) begin
        hold_vld <= 1'b0;
      end
      if (state == F_SUM) begin
        filtered <= filt_sum[MV_W] ? MV_MAX : filt_sum[MV_W-1:0];
      end
      if (q_push) begin
        batt_class  <= batt_next;
        estop_class <= estop_next;
        pwr_class   <= pwr_next;
        rail_class  <= rail_next;
        relay       <= relay_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      hold_perm  <= perm_raw;
      hold_power <= power_raw;
      hold_rail  <= rail_raw;
    end
    if (take) begin
      sc_perm <= scale_mv(raw_t'(hold_perm));
      sc_pw   <= scale_mv(raw_t'(hold_power));
      sc_rl   <= scale_mv(raw_t'(hold_rail));
    end
    if (state == F_MUL) begin
      prod_old <= PROD_W'(filtered) * PROD_W'(PCT_FULL - pct);
      prod_new <= PROD_W'(sc_perm) * PROD_W'(pct);
    end
    if (state == F_DIV) begin
      q_old <= div100(prod_old);
      q_new <= div100(prod_new);
    end
  end

endmodule

FILE: rtl/svm_back.sv
module svm_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  svm_pkg::rec_t  q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output svm_pkg::word_t word
);
  import svm_pkg::*;

  logic [CHG_W-1:0] sent;
  logic [CHG_W-1:0] remaining;
  logic [CHG_W-1:0] pick;
  logic             out_vld;
  logic             load;
  word_t            word_next;

  assign empty     = !out_vld;
  assign load      = !q_empty && (!out_vld || pop);
  assign remaining = q_head.chg & ~sent;
  assign q_pop     = load && (remaining == '0);

  // Changes go out in order battery, stop, power, rail; the summary closes.
  always_comb begin
    pick                    = '0;
    word_next.is_summary    = 1'b0;
    word_next.last          = 1'b0;
    word_next.filtered_mv   = q_head.filtered;
    word_next.power_mv      = q_head.power_mv;
    word_next.rail_mv       = q_head.rail_mv;
    word_next.resistor_on   = q_head.relay;
    word_next.battery_ok    = (q_head.batt_class != BATT_LOW);
    word_next.rail_ok       = q_head.rail_ok;
    word_next.estop_pressed = q_head.estop;
    priority if (remaining[CHG_BATT]) begin
      pick[CHG_BATT]       = 1'b1;
      // Battery class values double as their message codes.
      word_next.state_code = CODE_W'(q_head.batt_class);
    end else if (remaining[CHG_ESTOP]) begin
      pick[CHG_ESTOP]      = 1'b1;
      word_next.state_code = q_head.estop ? CODE_ESTOP_ON : CODE_ESTOP_OFF;
    end else if (remaining[CHG_POWER]) begin
      pick[CHG_POWER]      = 1'b1;
      word_next.state_code = q_head.pwr_avail ? CODE_POWER_OK : CODE_NO_POWER;
    end else if (remaining[CHG_RAIL]) begin
      pick[CHG_RAIL]       = 1'b1;
      word_next.state_code = q_head.rail_ok ? CODE_RAIL_OK : CODE_RAIL_BAD;
    end else begin
      word_next.state_code = CODE_SUMMARY;
      word_next.is_summary = 1'b1;
      word_next.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      sent    <= '0;
    end else begin
      if (load) begin
        out_vld <= 1'b1;
        sent    <= q_pop ? '0 : (sent | pick);
      end else if (pop) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_next;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import svm_pkg::*;

  localparam int ADC_W = ADC_BITS_DEF;
  localparam int RAW_MAX = (1 << ADC_W) - 1;
  localparam int NUM_REGS = 8;
  localparam int unsigned MV_NUM = 21500;
  localparam int unsigned MV_DEN = 600;
  localparam int unsigned FULL_SCALE = PCT_FULL;
  localparam int unsigned PCT_MASK = (1 << PCT_W) - 1;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 100;

  typedef enum logic [1:0] {PWR_UNKNOWN, PWR_AVAIL, PWR_NONE} pwr_class_t;

  typedef struct {
    logic [ADC_W-1:0] perm;
    logic [ADC_W-1:0] power;
    logic [ADC_W-1:0] rail;
  } acq_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [MV_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [ADC_W-1:0] perm_raw = '0;
  logic [ADC_W-1:0] power_raw = '0;
  logic [ADC_W-1:0] rail_raw = '0;
  logic empty;
  logic pop = 1'b0;
  logic is_summary;
  logic [CODE_W-1:0] state_code;
  logic [MV_W-1:0] filtered_mv;
  logic [MV_W-1:0] power_mv;
  logic [MV_W-1:0] rail_mv;
  logic resistor_on;
  logic battery_ok;
  logic rail_ok;
  logic estop_pressed;
  logic last;

  supply_voltage_monitor_unit dut (.*);

  // Predicted register contents and monitor state.
  logic [MV_W-1:0] limits [NUM_REGS] = '{16'd18000, 16'd21300, 16'd18000, 16'd16000,
                                         16'd10000, 16'd14000, 16'd1500, 16'd10};
  logic [MV_W-1:0] filt_mv = FILTER_RESET;
  logic [1:0] batt_cls = BATT_OFF;
  logic estop_cls = 1'b1;
  pwr_class_t pwr_cls = PWR_UNKNOWN;
  logic rail_cls = 1'b0;
  logic relay = 1'b1;

  acq_t pending_acq[$];
  word_t expected_words[$];
  acq_t offered;
  word_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int rx_hold_left = 0;
  int items_accepted = 0;
  int words_seen = 0;
  int messages_expected = 0;
  int full_stalls = 0;
  int mismatches = 0;
  int settings_used = 1;
  int cycle_count = 0;

  initial forever #4 clk = ~clk;

  function automatic int unsigned to_mv(logic [ADC_W-1:0] raw);
    int unsigned mv;
    mv = (32'(raw) * MV_NUM) / MV_DEN;
    return (mv > MV_MAX) ? MV_MAX : mv;
  endfunction

  function automatic int mv_to_raw(int unsigned mv);
    int unsigned r;
    r = mv * MV_DEN / MV_NUM;
    return (r > RAW_MAX) ? RAW_MAX : int'(r);
  endfunction

  // Advances the predicted monitor state by one acquisition and queues the
  // change messages followed by the closing summary word.
  function automatic void predict_status_words(acq_t a);
    int unsigned perm, pw, rl, p, f, old, gap;
    logic [CODE_W-1:0] codes[$];
    logic [1:0] nb;
    logic ne, nr;
    pwr_class_t np;
    word_t w;
    perm = to_mv(a.perm);
    pw = to_mv(a.power);
    rl = to_mv(a.rail);
    p = (limits[REG_FILTER_PCT] > FULL_SCALE) ? FULL_SCALE : limits[REG_FILTER_PCT];
    old = filt_mv;
    f = (old * (FULL_SCALE - p)) / FULL_SCALE + (perm * p) / FULL_SCALE;
    if (f > MV_MAX) f = MV_MAX;
    filt_mv = MV_W'(f);

    if (f < limits[REG_BATTERY_OFF]) nb = BATT_OFF;
    else if (f < limits[REG_BATTERY_LOW]) nb = BATT_LOW;
    else nb = BATT_GOOD;
    if (nb != batt_cls) begin
      batt_cls = nb;
      codes.push_back(CODE_W'(nb));
    end

    // A gap larger than the filtered voltage wraps, so the stop reads pressed.
    gap = limits[REG_ESTOP_GAP];
    ne = (f < gap) || (pw < f - gap);
    if (ne != estop_cls) begin
      estop_cls = ne;
      codes.push_back(ne ? CODE_ESTOP_ON : CODE_ESTOP_OFF);
    end

    np = pwr_cls;
    if (pw > limits[REG_POWER_ON]) begin
      np = PWR_AVAIL;
      relay = 1'b0;
    end else if (pw < limits[REG_POWER_OFF]) begin
      np = PWR_NONE;
      relay = 1'b1;
    end
    if (np != pwr_cls) begin
      pwr_cls = np;
      codes.push_back(np == PWR_AVAIL ? CODE_POWER_OK : CODE_NO_POWER);
    end

    nr = (rl > limits[REG_RAIL_MIN]) && (rl < limits[REG_RAIL_MAX]);
    if (nr != rail_cls) begin
      rail_cls = nr;
      codes.push_back(nr ? CODE_RAIL_OK : CODE_RAIL_BAD);
    end

    w.filtered_mv = filt_mv;
    w.power_mv = MV_W'(pw);
    w.rail_mv = MV_W'(rl);
    w.resistor_on = relay;
    w.battery_ok = (batt_cls != BATT_LOW);
    w.rail_ok = rail_cls;
    w.estop_pressed = estop_cls;
    w.is_summary = 1'b0;
    w.last = 1'b0;
    foreach (codes[k]) begin
      w.state_code = codes[k];
      expected_words.push_back(w);
    end
    messages_expected += codes.size();
    w.is_summary = 1'b1;
    w.last = 1'b1;
    w.state_code = CODE_SUMMARY;
    expected_words.push_back(w);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [MV_W-1:0] got, logic [MV_W-1:0] want_val);
    if (got !== want_val)
      report_mismatch($sformatf("word %0d: %s is %0h, expected %0h",
                                words_seen, name, got, want_val));
  endtask

  // Sender: holds an item until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_status_words(offered);
        items_accepted++;
      end
      if (push && full) full_stalls++;
      if (!push || !full) begin
        if (pending_acq.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_acq.pop_front();
          push <= 1'b1;
          perm_raw <= offered.perm;
          power_raw <= offered.power;
          rail_raw <= offered.rail;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every word taken against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with no word expected", words_seen));
        end else begin
          want = expected_words.pop_front();
          check_field("is_summary", is_summary, want.is_summary);
          check_field("state_code", state_code, want.state_code);
          check_field("filtered_mv", filtered_mv, want.filtered_mv);
          check_field("power_mv", power_mv, want.power_mv);
          check_field("rail_mv", rail_mv, want.rail_mv);
          check_field("resistor_on", resistor_on, want.resistor_on);
          check_field("battery_ok", battery_ok, want.battery_ok);
          check_field("rail_ok", rail_ok, want.rail_ok);
          check_field("estop_pressed", estop_pressed, want.estop_pressed);
          check_field("last", last, want.last);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, expected_words.size());
      $display("FAIL supply_voltage_monitor_unit");
      $finish;
    end
  end

  task automatic add_acq(int p, int w, int r, int times = 1);
    acq_t a;
    a.perm = ADC_W'(p);
    a.power = ADC_W'(w);
    a.rail = ADC_W'(r);
    repeat (times) pending_acq.push_back(a);
  endtask

  function automatic int near_raw(int center);
    int v;
    if ($urandom_range(99) < 30) return $urandom_range(RAW_MAX);
    v = center + int'($urandom_range(80)) - 40;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v;
  endfunction

  // Readings cluster around the current thresholds so that classes keep
  // flipping; a share of them is drawn over the full range.
  task automatic queue_random(int count);
    int perm_c, pow_c, rail_c;
    int unsigned below;
    for (int i = 0; i < count; i++) begin
      perm_c = mv_to_raw($urandom_range(1) ? limits[REG_BATTERY_OFF] : limits[REG_BATTERY_LOW]);
      below = (filt_mv > limits[REG_ESTOP_GAP]) ? filt_mv - limits[REG_ESTOP_GAP] : 0;
      case ($urandom_range(2))
        0: pow_c = mv_to_raw(limits[REG_POWER_ON]);
        1: pow_c = mv_to_raw(limits[REG_POWER_OFF]);
        default: pow_c = mv_to_raw(below);
      endcase
      rail_c = mv_to_raw($urandom_range(1) ? limits[REG_RAIL_MIN] : limits[REG_RAIL_MAX]);
      add_acq(near_raw(perm_c), near_raw(pow_c), near_raw(rail_c));
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [MV_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    limits[idx] = (idx == REG_FILTER_PCT) ? (val & MV_W'(PCT_MASK)) : val;
  endtask

  task automatic apply_settings(logic [MV_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_ADDR_W'(i), vals[i]);
    settings_used++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_acq.size() != 0 || push || expected_words.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [MV_W-1:0] v [NUM_REGS];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds. The first power reading sits in the hysteresis band,
    // so the unknown power class must not produce a message.
    send_idle_pct = 37;
    recv_idle_pct = 85;
    add_acq(600, 470, 335, 2);
    add_acq(600, RAW_MAX, 335);
    add_acq(600, 470, 335);
    add_acq(600, 0, 0);
    add_acq(RAW_MAX, RAW_MAX, RAW_MAX);
    add_acq(0, 0, 0);
    add_acq(0, RAW_MAX, 0);
    add_acq(RAW_MAX, 0, RAW_MAX);
    add_acq(0, 700, 335, 3);
    add_acq(RAW_MAX, 700, 335, 4);
    add_acq(600, 600, 280);
    add_acq(600, 600, 279);
    add_acq(600, 600, 390);
    add_acq(600, 600, 391);
    add_acq(600, 446, 335);
    add_acq(600, 503, 335);
    queue_random(110);
    wait_drained();

    // Every threshold at its top and a filter weight beyond full scale; the
    // stop gap exceeds any filtered voltage.
    send_idle_pct = 85;
    recv_idle_pct = 37;
    foreach (v[i]) v[i] = MV_MAX;
    v[REG_FILTER_PCT] = MV_W'(PCT_MASK);
    apply_settings(v);
    queue_random(50);
    wait_drained();

    // Long receiver stall while the sender keeps offering.
    hold_requests++;
    send_idle_pct = 0;
    queue_random(40);
    wait_drained();

    // Everything at zero: the filter stops moving.
    send_idle_pct = 85;
    foreach (v[i]) v[i] = '0;
    apply_settings(v);
    queue_random(50);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int s = 0; s < 2; s++) begin
      v[REG_BATTERY_OFF] = MV_W'($urandom_range(20000, 14000));
      v[REG_BATTERY_LOW] = MV_W'(v[REG_BATTERY_OFF] + $urandom_range(4000));
      v[REG_POWER_ON] = MV_W'($urandom_range(22000, 15000));
      v[REG_POWER_OFF] = MV_W'(v[REG_POWER_ON] - $urandom_range(3000));
      v[REG_RAIL_MIN] = MV_W'($urandom_range(12000, 8000));
      v[REG_RAIL_MAX] = MV_W'(v[REG_RAIL_MIN] + $urandom_range(5000));
      v[REG_ESTOP_GAP] = MV_W'($urandom_range(4000));
      v[REG_FILTER_PCT] = MV_W'($urandom_range(FULL_SCALE, 1));
      apply_settings(v);
      queue_random(55);
      wait_drained();
    end
    for (int s = 0; s < 2; s++) begin
      foreach (v[i]) v[i] = MV_W'($urandom_range(MV_MAX));
      v[REG_FILTER_PCT] = MV_W'($urandom_range(PCT_MASK));
      apply_settings(v);
      queue_random(55);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Ran %0d acquisitions under %0d threshold settings;",
             items_accepted, settings_used);
    $display("%0d words checked, %0d of them change messages.",
             words_seen, messages_expected);
    $display("Input stalled by a full block for %0d cycles; %0d mismatches found.",
             full_stalls, mismatches);
    if (mismatches == 0) begin
      $display("PASS supply_voltage_monitor_unit");
    end else begin
      $display("FAIL supply_voltage_monitor_unit");
    end
    $finish;
  end

endmodule
